### hw/rtl/cgi_pkg.sv
// Package for the color gradient interpolator.
// Holds field widths and the command and status types shared by the controller and datapath.
// No dependencies.
package cgi_pkg;

   localparam int COLOR_W = 32;
   localparam int CHAN_W = 8;
   localparam int NUM_CHAN = 4;
   localparam int CHAN_IDX_W = 2;
   localparam int DIST_W = 16;
   localparam int STEP_W = 32;
   localparam int REQ_DATA_W = 80;

   typedef struct packed {
      logic load;
      logic div_start;
      logic acc_en;
      logic mul_en;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic last_chan;
   } status_type;

endpackage

### hw/rtl/cgi_div.sv
// Restoring divider for one channel magnitude, one quotient bit per cycle.
// Depends on cgi_pkg for the channel and distance widths.
module cgi_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [cgi_pkg::CHAN_W-1:0] dividend,
   input  logic [cgi_pkg::DIST_W-1:0] divisor,
   output logic                       done,
   output logic [cgi_pkg::CHAN_W-1:0] quotient
);
   import cgi_pkg::*;

   localparam int CNT_W = $clog2(CHAN_W);

   logic              busy_ff, busy_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CHAN_W-1:0] rem_ff, rem_in;
   logic [CHAN_W-1:0] qd_ff, qd_in;
   logic [DIST_W-1:0] divisor_ff, divisor_in;
   logic [CHAN_W:0]   shifted;
   logic [CHAN_W:0]   diff;
   logic              ge;

   always_comb begin
      shifted = {rem_ff, qd_ff[CHAN_W-1]};
      ge = {{(DIST_W-CHAN_W-1){1'b0}}, shifted} >= divisor_ff;
      diff = shifted - divisor_ff[CHAN_W:0];
      done = busy_ff && (cnt_ff == CNT_W'(CHAN_W-1));
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      qd_in = qd_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         qd_in = dividend;
         divisor_in = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? diff[CHAN_W-1:0] : shifted[CHAN_W-1:0];
         qd_in = {qd_ff[CHAN_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (done) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      qd_ff <= qd_in;
      divisor_ff <= divisor_in;
   end

   assign quotient = qd_ff;

endmodule

### hw/rtl/cgi_ctrl.sv
// Controller state machine for the color gradient interpolator.
// Sequences the four channel divisions, the scaling multiply and the output register.
// Depends on cgi_pkg for the command and status types.
module cgi_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output cgi_pkg::cmd_type      cmd,
   input  cgi_pkg::status_type   status
);
   import cgi_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_START = 3'd1;
   localparam logic [2:0] ST_WAIT  = 3'd2;
   localparam logic [2:0] ST_ACC   = 3'd3;
   localparam logic [2:0] ST_MUL   = 3'd4;
   localparam logic [2:0] ST_FIN   = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       valid_ff, valid_in;

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff && !rsp_tready;
      cmd = '0;
      req_tready = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_START;
            end
         end
         ST_START: begin
            cmd.div_start = 1'b1;
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (status.div_done) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            cmd.acc_en = 1'b1;
            state_in = status.last_chan ? ST_MUL : ST_START;
         end
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;

endmodule

### hw/rtl/cgi_dp.sv
// Datapath for the color gradient interpolator: beat capture, step counter,
// channel differences, shared divider, packed quotient sum, multiply and output register.
// Depends on cgi_pkg and cgi_div.
module cgi_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [cgi_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                            req_tuser,
   output logic [cgi_pkg::COLOR_W-1:0]     rsp_tdata,
   input  cgi_pkg::cmd_type                cmd,
   output cgi_pkg::status_type             status
);
   import cgi_pkg::*;

   logic [COLOR_W-1:0]    start_ff, start_in;
   logic [COLOR_W-1:0]    end_ff, end_in;
   logic [DIST_W-1:0]     dist_ff, dist_in;
   logic [STEP_W-1:0]     step_cnt_ff, step_cnt_in;
   logic [STEP_W-1:0]     n_ff, n_in;
   logic [CHAN_IDX_W-1:0] chan_ff, chan_in;
   logic [COLOR_W-1:0]    qsum_ff, qsum_in;
   logic [COLOR_W-1:0]    prod_ff, prod_in;
   logic [COLOR_W-1:0]    pix_ff, pix_in;
   logic [STEP_W-1:0]     step_used;
   logic [CHAN_W-1:0]     s_chan, e_chan;
   logic [CHAN_W:0]       diff;
   logic                  neg;
   logic [CHAN_W-1:0]     mag;
   logic [CHAN_W-1:0]     quotient;
   logic                  div_done;
   logic [CHAN_W:0]       q_signed;
   logic [COLOR_W-1:0]    term;

   always_comb begin
      s_chan = start_ff[chan_ff*CHAN_W +: CHAN_W];
      e_chan = end_ff[chan_ff*CHAN_W +: CHAN_W];
      diff = {1'b0, e_chan} - {1'b0, s_chan};
      neg = diff[CHAN_W];
      mag = neg ? CHAN_W'(-diff) : diff[CHAN_W-1:0];
   end

   cgi_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (mag),
      .divisor  (dist_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      q_signed = neg ? -{1'b0, quotient} : {1'b0, quotient};
      if (dist_ff == '0) begin
         q_signed = '0;
      end
      term = {{(COLOR_W-CHAN_W-1){q_signed[CHAN_W]}}, q_signed} << {chan_ff, 3'b000};
      step_used = req_tuser ? '0 : step_cnt_ff;

      start_in = start_ff;
      end_in = end_ff;
      dist_in = dist_ff;
      step_cnt_in = step_cnt_ff;
      n_in = n_ff;
      chan_in = chan_ff;
      qsum_in = qsum_ff;
      prod_in = prod_ff;
      pix_in = pix_ff;
      if (cmd.load) begin
         start_in = req_tdata[COLOR_W-1:0];
         end_in = req_tdata[2*COLOR_W-1:COLOR_W];
         dist_in = req_tdata[2*COLOR_W+DIST_W-1:2*COLOR_W];
         n_in = step_used;
         step_cnt_in = step_used + 1'b1;
         chan_in = '0;
         qsum_in = '0;
      end
      if (cmd.acc_en) begin
         qsum_in = qsum_ff + term;
         chan_in = chan_ff + 1'b1;
      end
      if (cmd.mul_en) begin
         prod_in = COLOR_W'(qsum_ff * n_ff);
      end
      if (cmd.out_load) begin
         pix_in = start_ff + prod_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_cnt_ff <= '0;
         chan_ff <= '0;
      end else begin
         step_cnt_ff <= step_cnt_in;
         chan_ff <= chan_in;
      end
      start_ff <= start_in;
      end_ff <= end_in;
      dist_ff <= dist_in;
      n_ff <= n_in;
      qsum_ff <= qsum_in;
      prod_ff <= prod_in;
      pix_ff <= pix_in;
   end

   assign status.div_done = div_done;
   assign status.last_chan = (chan_ff == CHAN_IDX_W'(NUM_CHAN-1));
   assign rsp_tdata = pix_ff;

endmodule

### hw/rtl/color_gradient_interpolator_core.sv
// Top level of the color gradient interpolator.
// Joins the controller cgi_ctrl and the datapath cgi_dp; depends on cgi_pkg.
//
// Usage: each beat on the req_ channel carries one pixel of a line: start color,
// end color, line length and, in req_tuser, a flag that marks the first pixel of
// a line and clears the step counter. Each beat gives exactly one beat on the
// rsp_ channel with the interpolated color.
// Sequence: after a beat is accepted, each of the four channels passes in turn
// through the shared bit-serial divider (start, eight quotient bits, accumulate),
// followed by the multiply step and the output step.
// The single shared divider serves the channels one after another.
// The block takes one beat at a time; req_tready is high while it is idle.
// The result sits in an output register, so the next beat is accepted while a
// finished result still waits on a stalled receiver. If the receiver stalls
// longer, the next result waits in the last step until the register frees.
// Reset clears the step counter, the controller and the output valid flag.
module color_gradient_interpolator_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // Fields from bit 0: start_color[31:0], end_color[63:32], distance[79:64].
   input  logic [cgi_pkg::REQ_DATA_W-1:0] req_tdata,
   // Fields from bit 0: restart.
   input  logic                           req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // Fields from bit 0: pixel_color[31:0].
   output logic [cgi_pkg::COLOR_W-1:0]    rsp_tdata
);
   import cgi_pkg::*;

   cmd_type    cmd;
   status_type status;

   cgi_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   cgi_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .cmd       (cmd),
      .status    (status)
   );

endmodule
